// ----- rtl/core/modular_inverse_ext_euclid_defines.svh -----
// Assertion macros used by the modular inverse checker.
`ifndef MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MEUC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MEUC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/meuc_pkg.sv -----
// Shared widths and control structs for the modular inverse block.
package meuc_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned FIELD_W    = 63;
  localparam int unsigned STEP_CNT_W = $clog2(WORD_W + 1);

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [FIELD_W-1:0] field_t;

  // Command to the shared divide / multiply-accumulate unit.
  typedef struct packed {
    logic  start;
    word_t dividend;
    field_t divisor;
    word_t coef;      // multiplied by the quotient as it is formed
  } div_cmd_t;

  // Result of the shared unit.
  typedef struct packed {
    logic   done;
    field_t rem;
    word_t  prod;     // quotient * coef, mod 2^WORD_W
  } div_rsp_t;

endpackage

// ----- rtl/core/meuc_stream_if.sv -----
// Valid/ready channel interfaces for the modular inverse block.
interface meuc_in_if;
  import meuc_pkg::*;
  logic   valid;
  logic   ready;
  field_t value;
  field_t modulus;
  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface meuc_out_if;
  import meuc_pkg::*;
  logic   valid;
  logic   ready;
  field_t inverse;
  field_t divisor;
  modport source (output valid, output inverse, output divisor, input ready);
  modport sink   (input valid, input inverse, input divisor, output ready);
endinterface

// ----- rtl/core/meuc_div.sv -----
// Radix-2 restoring divider with quotient * coef accumulate, one bit per cycle.
module meuc_div import meuc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_rsp_t rsp
);

  word_t                 dvd_r;
  field_t                dsr_r;
  word_t                 coef_r;
  field_t                rem_r;
  word_t                 acc_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic                  run_r;
  logic                  done_r;

  word_t sh;
  word_t diff;
  logic  take;

  always_comb begin
    sh   = {rem_r, dvd_r[WORD_W-1]};
    diff = sh - {1'b0, dsr_r};
    take = (sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        run_r <= 1'b1;
        cnt_r <= STEP_CNT_W'(WORD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - STEP_CNT_W'(1);
        if (cnt_r == STEP_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r  <= cmd.dividend;
      dsr_r  <= cmd.divisor;
      coef_r <= cmd.coef;
      rem_r  <= '0;
      acc_r  <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
      rem_r <= take ? diff[FIELD_W-1:0] : sh[FIELD_W-1:0];
      acc_r <= {acc_r[WORD_W-2:0], 1'b0} + (take ? coef_r : '0);
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;
  assign rsp.prod = acc_r;

endmodule

// ----- rtl/core/modular_inverse_ext_euclid.sv -----
// Modular inverse by the extended Euclidean algorithm, one shared divider.
// Each input runs k Euclid steps (k at most about 92), then a closing reduction
//   unless the modulus is zero; a step is a CHECK state, a divider run and the
//   divider's done response.
// Throughput: one beat at a time; in_ch.ready is high only while idle.
// Reset (rst_n low, synchronous): sequencer to idle, output beat dropped.
module modular_inverse_ext_euclid import meuc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  meuc_in_if.sink    in_ch,
  meuc_out_if.source out_ch
);

  // Sequencer states
  //   IDLE   : wait for an input beat
  //   CHECK  : decide next Euclid step, or start the final reduction
  //   STEP   : divider running r0 / r1 with q * s1 alongside
  //   REDUCE : divider running |s0| mod modulus
  //   FIN    : hand the result to the output register
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_REDUCE = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Euclid working set: remainders and signed (two's complement) coefficients
  field_t r0_r, r1_r, mod_r;
  word_t  s0_r, s1_r;
  logic   neg_r;
  field_t inv_r;

  // output register, decouples the sequencer from a stalled sink
  logic   out_valid_r;
  field_t out_inv_r, out_gcd_r;

  div_cmd_t div_cmd;
  div_rsp_t div_rsp;

  logic   in_beat;
  logic   euclid_go;
  logic   load_out;
  word_t  s0_mag;
  field_t wrap;

  meuc_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign euclid_go   = (r1_r != '0);
  assign load_out    = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign s0_mag      = ~s0_r + word_t'(1);
  // negative coefficient: modulus minus the reduced magnitude
  assign wrap        = mod_r - div_rsp.rem;

  // One shared divider: Euclid steps divide r0 by r1 and accumulate q * s1;
  // the closing pass divides |s0| by the modulus.
  always_comb begin
    div_cmd.start    = (state_r == ST_CHECK) && (euclid_go || (mod_r != '0));
    div_cmd.dividend = euclid_go ? {1'b0, r0_r} : (s0_r[WORD_W-1] ? s0_mag : s0_r);
    div_cmd.divisor  = euclid_go ? r1_r : mod_r;
    div_cmd.coef     = euclid_go ? s1_r : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (euclid_go)          state_nxt = ST_STEP;
        else if (mod_r != '0)   state_nxt = ST_REDUCE;
        else                    state_nxt = ST_FIN;
      end
      ST_STEP: begin
        if (div_rsp.done) state_nxt = ST_CHECK;
      end
      ST_REDUCE: begin
        if (div_rsp.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      r0_r  <= in_ch.value;
      r1_r  <= in_ch.modulus;
      mod_r <= in_ch.modulus;
      s0_r  <= word_t'(1);
      s1_r  <= '0;
    end
    if (state_r == ST_CHECK) begin
      neg_r <= s0_r[WORD_W-1];
      // zero modulus: gcd is the value, inverse pinned at zero
      if (!euclid_go && (mod_r == '0)) inv_r <= '0;
    end
    if ((state_r == ST_STEP) && div_rsp.done) begin
      r0_r <= r1_r;
      r1_r <= div_rsp.rem;
      s0_r <= s1_r;
      s1_r <= s0_r - div_rsp.prod;
    end
    if ((state_r == ST_REDUCE) && div_rsp.done) begin
      if (neg_r && (div_rsp.rem != '0)) inv_r <= wrap;
      else if (neg_r)                   inv_r <= '0;
      else                              inv_r <= div_rsp.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_inv_r <= inv_r;
      out_gcd_r <= r0_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.inverse = out_inv_r;
  assign out_ch.divisor = out_gcd_r;

endmodule

// ----- rtl/core/meuc_chk.sv -----
// Port-level checker for the modular inverse block, with its bind.
`include "modular_inverse_ext_euclid_defines.svh"

module meuc_chk import meuc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input field_t out_inverse,
  input field_t out_divisor
);

  // stalled result beat holds
  `MEUC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_inverse) && $stable(out_divisor), "output beat changed while stalled")

  // one item at a time: busy right after an accepted beat
  `MEUC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready while an item is in work")

  // no result appears in the cycle right after acceptance
  `MEUC_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid), "result before any work done")

  // gcd of zero only for zero value and zero modulus, where inverse is zero
  `MEUC_ASSERT_SAME(a_zero_gcd, out_valid && (out_divisor == '0), out_inverse == '0, "nonzero inverse with zero gcd")

endmodule

bind modular_inverse_ext_euclid meuc_chk u_meuc_chk (
  .clk (clk),
  .rst_n (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_inverse (out_ch.inverse),
  .out_divisor (out_ch.divisor)
);
